@@ rtl/ilcs_pkg.sv @@
package ilcs_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_DELETED  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_INVALID  = 3'd3,
        ST_FULL     = 3'd4,
        ST_ELEMENT  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_SHIFT  = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_cell_op                   op;
        logic [POS_W-1:0]           pos;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctl;

endpackage

@@ rtl/ilcs_if.sv @@
interface ilcs_in_if;
    logic                                valid;
    logic                                ready;
    logic [ilcs_pkg::CMD_W-1:0]          command;
    logic signed [ilcs_pkg::VALUE_W-1:0] value;
    logic [ilcs_pkg::POS_W-1:0]          position;

    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface

interface ilcs_out_if;
    logic                                valid;
    logic                                ready;
    logic [ilcs_pkg::STATUS_W-1:0]       status;
    logic signed [ilcs_pkg::VALUE_W-1:0] element;
    logic                                last;

    modport source (output valid, status, element, last, input ready);
    modport sink   (input valid, status, element, last, output ready);
endinterface

@@ rtl/ilcs_cell.sv @@
module ilcs_cell #(
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  ilcs_pkg::t_cell_ctl                 i_ctl,
    input  logic [CW-1:0]                       i_count,
    input  logic signed [ilcs_pkg::VALUE_W-1:0] i_next,
    input  logic signed [ilcs_pkg::VALUE_W-1:0] i_head,
    output logic signed [ilcs_pkg::VALUE_W-1:0] o_data
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic signed [ilcs_pkg::VALUE_W-1:0] r_data;
    logic signed [ilcs_pkg::VALUE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            ilcs_pkg::CELL_LOAD: begin
                if (i_count == MY_IDX) begin
                    n_data = i_ctl.value;
                end
            end
            ilcs_pkg::CELL_SHIFT: begin
                // close the gap: everything at or above the hole moves down one
                if (IDX >= int'(i_ctl.pos)) begin
                    n_data = i_next;
                end
            end
            ilcs_pkg::CELL_ROTATE: begin
                // last valid cell takes the head word, the rest take their neighbor
                if (i_count - CW'(1) == MY_IDX) begin
                    n_data = i_head;
                end else begin
                    n_data = i_next;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ rtl/indexed_list_compacting_store_core.sv @@
// Ordered list of up to CAPACITY signed 32-bit words held in a chain of cells.
// Input channel i_cmd carries command, value and position; output channel
// o_res carries status, element and last. A word moves when valid and ready
// are both high on a rising edge of i_clk.
// Append and delete: one word in, one result word out. The cell chain is
// updated on the accepting edge and the result sits in the output register
// from the next cycle, so a new command can follow every cycle as long as
// the receiver keeps taking results.
// Readout: count result words, one per cycle while the receiver takes them,
// last set on the final one; the chain rotates through its valid cells once
// per word and ends in its original order. Every element word comes from
// the single head cell that feeds the output. An empty list gives one empty word.
// Command 3 is taken and gives no result.
// When o_res.ready is low the result is held and the chain stops rotating;
// i_cmd.ready is low during readout and while a result is held.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// result; the stored words themselves are not cleared.
module indexed_list_compacting_store_core #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilcs_in_if.sink     i_cmd,
    ilcs_out_if.source  o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    ilcs_pkg::t_state r_state;
    ilcs_pkg::t_state n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_rd_idx;
    logic [CW-1:0]    n_rd_idx;

    logic                                r_out_valid;
    logic                                n_out_valid;
    ilcs_pkg::t_status                   r_out_status;
    ilcs_pkg::t_status                   n_out_status;
    logic signed [ilcs_pkg::VALUE_W-1:0] r_out_element;
    logic signed [ilcs_pkg::VALUE_W-1:0] n_out_element;
    logic                                r_out_last;
    logic                                n_out_last;

    ilcs_pkg::t_cell_ctl                 cell_ctl;
    logic signed [ilcs_pkg::VALUE_W-1:0] cell_data [CAPACITY];

    logic         out_free;
    logic         in_acc;
    ilcs_pkg::t_cmd cmd;
    logic         pos_past_end;
    logic         rd_final;

    assign out_free     = !r_out_valid || o_res.ready;
    assign i_cmd.ready  = (r_state == ilcs_pkg::S_IDLE) && out_free;
    assign in_acc       = i_cmd.valid && i_cmd.ready;
    assign cmd          = ilcs_pkg::t_cmd'(i_cmd.command);
    assign pos_past_end = 32'(i_cmd.position) >= 32'(r_count);
    assign rd_final     = r_rd_idx == r_count - CW'(1);

    // cell chain: each cell sees its upper neighbor (the last cell sees itself) and the head cell
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_end
            ilcs_cell #(.CW(CW), .IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl),
                .i_count (r_count),
                .i_next  (cell_data[g]),
                .i_head  (cell_data[0]),
                .o_data  (cell_data[g])
            );
        end else begin : g_mid
            ilcs_cell #(.CW(CW), .IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl),
                .i_count (r_count),
                .i_next  (cell_data[g+1]),
                .i_head  (cell_data[0]),
                .o_data  (cell_data[g])
            );
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ilcs_pkg::S_IDLE: begin
                if (in_acc && cmd == ilcs_pkg::CMD_READ && r_count != '0) begin
                    n_state = ilcs_pkg::S_READ;
                end
            end
            ilcs_pkg::S_READ: begin
                if (out_free && rd_final) begin
                    n_state = ilcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ilcs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid    = r_out_valid && !o_res.ready;
        n_out_status   = r_out_status;
        n_out_element  = r_out_element;
        n_out_last     = r_out_last;
        n_count        = r_count;
        n_rd_idx       = r_rd_idx;
        cell_ctl.op    = ilcs_pkg::CELL_HOLD;
        cell_ctl.pos   = i_cmd.position;
        cell_ctl.value = i_cmd.value;
        case (r_state)
            ilcs_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_out_element = '0;
                    n_out_last    = 1'b1;
                    case (cmd)
                        ilcs_pkg::CMD_APPEND: begin
                            n_out_valid = 1'b1;
                            if (r_count == CAP_C) begin
                                n_out_status = ilcs_pkg::ST_FULL;
                            end else begin
                                n_out_status = ilcs_pkg::ST_APPENDED;
                                cell_ctl.op  = ilcs_pkg::CELL_LOAD;
                                n_count      = r_count + CW'(1);
                            end
                        end
                        ilcs_pkg::CMD_DELETE: begin
                            n_out_valid = 1'b1;
                            if (r_count == '0) begin
                                n_out_status = ilcs_pkg::ST_EMPTY;
                            end else if (pos_past_end) begin
                                n_out_status = ilcs_pkg::ST_INVALID;
                            end else begin
                                n_out_status = ilcs_pkg::ST_DELETED;
                                cell_ctl.op  = ilcs_pkg::CELL_SHIFT;
                                n_count      = r_count - CW'(1);
                            end
                        end
                        ilcs_pkg::CMD_READ: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ilcs_pkg::ST_EMPTY;
                            end else begin
                                n_rd_idx = '0;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            ilcs_pkg::S_READ: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = ilcs_pkg::ST_ELEMENT;
                    n_out_element = cell_data[0];
                    n_out_last    = rd_final;
                    cell_ctl.op   = ilcs_pkg::CELL_ROTATE;
                    n_rd_idx      = r_rd_idx + CW'(1);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ilcs_pkg::S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status  <= n_out_status;
        r_out_element <= n_out_element;
        r_out_last    <= n_out_last;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out_status;
    assign o_res.element = r_out_element;
    assign o_res.last    = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("list count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_count != $past(r_count) |->
            r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1))
        else $error("list count moved by more than one");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ilcs_pkg::S_READ |-> r_count != '0 && r_rd_idx < r_count)
        else $error("readout index outside the list");

    a_last_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_out_status == ilcs_pkg::ST_ELEMENT)
        else $error("non-final word that is not an element");

    a_no_count_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_state) == ilcs_pkg::S_READ |-> $stable(r_count))
        else $error("count changed during readout");

endmodule
